@@ rtl/rcst_pkg.sv @@
`default_nettype none

package rcst_pkg;

   // Fixed field widths
   localparam int CMD_W   = 3;
   localparam int IDX_W   = 4;
   localparam int COUNT_W = 16;
   localparam int ID_W    = 31;
   localparam int ST_W    = 3;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
   localparam logic [ID_W-1:0]    ID_MAX    = {ID_W{1'b1}};

   // Free bitmap is searched this many slots per cycle
   localparam int SCAN_CHUNK = 16;

   typedef enum logic [CMD_W-1:0] {
      CMD_CREATE  = 3'd0,
      CMD_DUP     = 3'd1,
      CMD_RELEASE = 3'd2,
      CMD_NEXT_ID = 3'd3,
      CMD_DEPTH   = 3'd4
   } cmd_type;

   typedef enum logic [ST_W-1:0] {
      ST_OK      = 3'd0,
      ST_FULL    = 3'd1,
      ST_UNDER   = 3'd2,
      ST_OVER    = 3'd3,
      ST_EXHAUST = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_MODIFY,
      S_WALK,
      S_DONE
   } state_type;

   // One table entry as held in the slot memory
   typedef struct packed {
      logic [COUNT_W-1:0] ref_count;
      logic               parent_valid;
      logic [IDX_W-1:0]   parent_slot;
      logic [ID_W-1:0]    id_counter;
   } slot_word_type;

endpackage

`default_nettype wire

@@ rtl/rcst_req_if.sv @@
`default_nettype none

interface rcst_req_if import rcst_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CMD_W-1:0] command;
   logic [IDX_W-1:0] slot_index;
   logic             slot_present;

   modport source (output valid, command, slot_index, slot_present, input ready);
   modport sink   (input valid, command, slot_index, slot_present, output ready);
endinterface

`default_nettype wire

@@ rtl/rcst_rsp_if.sv @@
`default_nettype none

interface rcst_rsp_if import rcst_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [IDX_W-1:0] result_slot;
   logic [ID_W-1:0]  issued_id;
   logic             at_max_depth;
   logic [ST_W-1:0]  status;

   modport source (output valid, result_slot, issued_id, at_max_depth, status, input ready);
   modport sink   (input valid, result_slot, issued_id, at_max_depth, status, output ready);
endinterface

`default_nettype wire

@@ rtl/refcounted_namespace_slot_table.sv @@
// Reference-counted slot table. Each of SLOTS slots holds a 16-bit count,
// an optional parent link and a 31-bit id counter, kept in one memory with
// a registered read. One item is worked at a time; its response goes to an
// output register, so the next item is taken while the response waits.
// Dup, release and next id go through read, modify/write and respond steps.
// Create searches a free bitmap 16 slots per cycle. Depth check reads one
// parent link per cycle from the memory. Slot indexes of SLOTS or more
// count as no slot. No clearing pass is needed after reset.
`default_nettype none

module refcounted_namespace_slot_table import rcst_pkg::*; #(
   parameter int SLOTS     = 16,
   parameter int MAX_DEPTH = 8
) (
   input wire logic   clock,
   input wire logic   reset,
   rcst_req_if.sink   req_ch,
   rcst_rsp_if.source rsp_ch
);

   localparam int ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CHUNK  = (SLOTS < SCAN_CHUNK) ? SLOTS : SCAN_CHUNK;
   localparam int NCHUNK = (SLOTS + CHUNK - 1) / CHUNK;
   localparam int PAD_W  = NCHUNK * CHUNK;
   localparam int CW     = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
   localparam int POS_W  = (CHUNK > 1) ? $clog2(CHUNK) : 1;
   localparam int DEP_W  = $clog2(MAX_DEPTH + 1);

   state_type          state_ff, state_in;
   logic [CMD_W-1:0]   cmd_ff, cmd_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic               have_ff, have_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic [CW-1:0]      chunk_ff, chunk_in;
   logic [DEP_W-1:0]   depth_ff, depth_in;

   logic [IDX_W-1:0]   res_slot_ff, res_slot_in;
   logic [ID_W-1:0]    res_id_ff, res_id_in;
   logic               res_deep_ff, res_deep_in;
   status_type         res_status_ff, res_status_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [ID_W-1:0]    rsp_id_ff, rsp_id_in;
   logic               rsp_deep_ff, rsp_deep_in;
   status_type         rsp_status_ff, rsp_status_in;

   logic [ADDR_W-1:0]  rd_addr;
   slot_word_type      rd_word;
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   slot_word_type      wr_word;
   logic [SLOTS-1:0]   free_vec;

   logic               req_accept;
   logic               req_have;
   logic [PAD_W-1:0]   free_pad;
   logic [CHUNK-1:0]   chunk_bits;
   logic               chunk_any;
   logic [POS_W-1:0]   chunk_pos;
   logic [31:0]        found_full;

   rcst_slot_store #(
      .SLOTS  (SLOTS),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .rd_addr  (rd_addr),
      .rd_word  (rd_word),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_word  (wr_word),
      .free_vec (free_vec)
   );

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_accept   = req_ch.valid && req_ch.ready;
   assign req_have     = req_ch.slot_present && (32'(req_ch.slot_index) < SLOTS);

   // Lowest free slot within the current chunk of the bitmap
   assign free_pad   = PAD_W'(free_vec);
   assign chunk_bits = free_pad[chunk_ff * CHUNK +: CHUNK];

   always_comb begin
      chunk_any = 1'b0;
      chunk_pos = '0;
      for (int i = CHUNK - 1; i >= 0; i--) begin
         if (chunk_bits[i]) begin
            chunk_any = 1'b1;
            chunk_pos = POS_W'(i);
         end
      end
   end

   assign found_full = 32'(chunk_ff) * CHUNK + 32'(chunk_pos);

   // Command sequencer: next state, memory access, result
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      idx_in        = idx_ff;
      have_in       = have_ff;
      addr_in       = addr_ff;
      chunk_in      = chunk_ff;
      depth_in      = depth_ff;
      res_slot_in   = res_slot_ff;
      res_id_in     = res_id_ff;
      res_deep_in   = res_deep_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_slot_in   = rsp_slot_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_deep_in   = rsp_deep_ff;
      rsp_status_in = rsp_status_ff;
      rd_addr       = addr_ff;
      wr_en         = 1'b0;
      wr_addr       = addr_ff;
      wr_word       = rd_word;

      unique case (state_ff)
         S_IDLE: begin
            rd_addr = ADDR_W'(req_ch.slot_index);
            if (req_accept) begin
               cmd_in        = req_ch.command;
               idx_in        = req_ch.slot_index;
               have_in       = req_have;
               addr_in       = ADDR_W'(req_ch.slot_index);
               chunk_in      = '0;
               depth_in      = DEP_W'(1);
               res_slot_in   = req_ch.slot_index;
               res_id_in     = '0;
               res_deep_in   = 1'b0;
               res_status_in = ST_OK;
               unique case (cmd_type'(req_ch.command))
                  CMD_CREATE: state_in = S_SCAN;
                  CMD_DUP, CMD_RELEASE, CMD_NEXT_ID: begin
                     state_in = req_have ? S_MODIFY : S_DONE;
                  end
                  CMD_DEPTH: begin
                     if (!req_have) begin
                        state_in = S_DONE;
                     end else if (MAX_DEPTH <= 1) begin
                        res_deep_in = 1'b1;
                        state_in    = S_DONE;
                     end else begin
                        state_in = S_WALK;
                     end
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end

         S_SCAN: begin
            if (chunk_any) begin
               wr_en                = 1'b1;
               wr_addr              = ADDR_W'(found_full);
               wr_word.ref_count    = COUNT_W'(1);
               wr_word.parent_valid = have_ff;
               wr_word.parent_slot  = have_ff ? idx_ff : '0;
               wr_word.id_counter   = ID_W'(1);
               res_slot_in          = IDX_W'(found_full);
               state_in             = S_DONE;
            end else if (chunk_ff == CW'(NCHUNK - 1)) begin
               res_slot_in   = '0;
               res_status_in = ST_FULL;
               state_in      = S_DONE;
            end else begin
               chunk_in = chunk_ff + CW'(1);
            end
         end

         // Read data is here: update the entry and write it back
         S_MODIFY: begin
            wr_en = 1'b1;
            unique case (cmd_type'(cmd_ff))
               CMD_DUP: begin
                  if (rd_word.ref_count == COUNT_MAX) begin
                     res_status_in = ST_OVER;
                  end else begin
                     wr_word.ref_count = rd_word.ref_count + COUNT_W'(1);
                  end
               end
               CMD_RELEASE: begin
                  if (rd_word.ref_count == '0) begin
                     res_status_in = ST_UNDER;
                  end else begin
                     wr_word.ref_count = rd_word.ref_count - COUNT_W'(1);
                  end
               end
               CMD_NEXT_ID: begin
                  if (rd_word.id_counter == ID_MAX) begin
                     res_status_in = ST_EXHAUST;
                  end else begin
                     res_id_in          = rd_word.id_counter;
                     wr_word.id_counter = rd_word.id_counter + ID_W'(1);
                  end
               end
               default: wr_en = 1'b0;
            endcase
            state_in = S_DONE;
         end

         // One parent link per cycle
         S_WALK: begin
            if (!rd_word.parent_valid) begin
               state_in = S_DONE;
            end else if (32'(rd_word.parent_slot) >= SLOTS) begin
               state_in = S_DONE;
            end else if (32'(depth_ff) + 1 >= MAX_DEPTH) begin
               res_deep_in = 1'b1;
               state_in    = S_DONE;
            end else begin
               depth_in = depth_ff + DEP_W'(1);
               rd_addr  = ADDR_W'(rd_word.parent_slot);
            end
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_slot_in   = res_slot_ff;
               rsp_id_in     = res_id_ff;
               rsp_deep_in   = res_deep_ff;
               rsp_status_in = res_status_ff;
               state_in      = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and payload registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      idx_ff        <= idx_in;
      have_ff       <= have_in;
      addr_ff       <= addr_in;
      chunk_ff      <= chunk_in;
      depth_ff      <= depth_in;
      res_slot_ff   <= res_slot_in;
      res_id_ff     <= res_id_in;
      res_deep_ff   <= res_deep_in;
      res_status_ff <= res_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_deep_ff   <= rsp_deep_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.result_slot  = rsp_slot_ff;
   assign rsp_ch.issued_id    = rsp_id_ff;
   assign rsp_ch.at_max_depth = rsp_deep_ff;
   assign rsp_ch.status       = rsp_status_ff;

endmodule

`default_nettype wire

@@ rtl/rcst_slot_store.sv @@
`default_nettype none

// Slot memory: one read and one write port, registered read data.
// Per-entry written bits make never-written entries read as all zero,
// and a free bitmap tracks which slots hold a zero count.
module rcst_slot_store import rcst_pkg::*; #(
   parameter int SLOTS  = 16,
   parameter int ADDR_W = 4
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [ADDR_W-1:0]   rd_addr,
   output      slot_word_type       rd_word,
   input  wire logic                wr_en,
   input  wire logic [ADDR_W-1:0]   wr_addr,
   input  wire slot_word_type       wr_word,
   output      logic [SLOTS-1:0]    free_vec
);

   slot_word_type    mem [SLOTS];
   slot_word_type    rd_data_ff;
   logic             rd_hit_ff;
   logic [SLOTS-1:0] written_ff;
   logic [SLOTS-1:0] free_ff;

   // Array storage and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_word;
      end
      rd_data_ff <= mem[rd_addr];
      rd_hit_ff  <= written_ff[rd_addr];
   end

   // Written and free bits
   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
         free_ff    <= '1;
      end else if (wr_en) begin
         written_ff[wr_addr] <= 1'b1;
         free_ff[wr_addr]    <= (wr_word.ref_count == '0);
      end
   end

   assign rd_word  = rd_hit_ff ? rd_data_ff : '0;
   assign free_vec = free_ff;

endmodule

`default_nettype wire

@@ rtl/rcst_checker.sv @@
`default_nettype none

module rcst_checker import rcst_pkg::*; (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire logic [IDX_W-1:0] rsp_result_slot,
   input wire logic [ID_W-1:0]  rsp_issued_id,
   input wire logic             rsp_at_max_depth,
   input wire logic [ST_W-1:0]  rsp_status
);

   // A stalled response item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_slot)
         && $stable(rsp_issued_id) && $stable(rsp_at_max_depth) && $stable(rsp_status))
      else $error("response changed while stalled");

   // One item in work at a time
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while an item is in work");

   // An id is issued only on success
   a_id_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_issued_id != '0 |-> rsp_status == ST_OK)
      else $error("issued id with error status");

   // Full table reports slot zero
   a_full_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FULL |-> rsp_result_slot == '0 && rsp_issued_id == '0)
      else $error("table full with nonzero slot or id");

   // Depth flag only with ok status
   a_depth_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_at_max_depth |-> rsp_status == ST_OK && rsp_issued_id == '0)
      else $error("depth flag with error status or id");

endmodule

bind refcounted_namespace_slot_table rcst_checker u_rcst_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_result_slot  (rsp_ch.result_slot),
   .rsp_issued_id    (rsp_ch.issued_id),
   .rsp_at_max_depth (rsp_ch.at_max_depth),
   .rsp_status       (rsp_ch.status)
);

`default_nettype wire
